// File: hw/rtl/jdi_pkg.sv
// Shared types, constants and helper functions for the Jacobian determinant/inverse block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
package jdi_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int QUEUE_DEPTH   = 2;

   localparam logic [1:0] DIMS_3D    = 2'd3;
   localparam logic [1:0] DIMS_RESET = 2'd2;

   typedef enum logic [1:0] {
      KIND_JAC = 2'd0,
      KIND_INV = 2'd1,
      KIND_DET = 2'd2
   } kind_type;

   // One finished point handed from front to back: saturated J entries, row-major r*3+c.
   typedef struct packed {
      logic             three;
      logic [8:0][31:0] m;
   } point_type;

   localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] S64_MIN = -64'sh7FFF_FFFF_FFFF_FFFF - 64'sd1;

   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b,
                                                  input logic sub);
      logic signed [64:0] s;
      s = sub ? ({a[63], a} - {b[63], b}) : ({a[63], a} + {b[63], b});
      if (s[64] != s[63]) begin
         return s[64] ? S64_MIN : S64_MAX;
      end
      return s[63:0];
   endfunction

   function automatic logic [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sh0000_0000_7FFF_FFFF) begin
         return 32'h7FFF_FFFF;
      end else if (v < -64'sh0000_0000_8000_0000) begin
         return 32'h8000_0000;
      end
      return v[31:0];
   endfunction

   function automatic logic signed [63:0] sext32(input logic [31:0] v);
      return {{32{v[31]}}, v};
   endfunction

   function automatic logic [3:0] idx9(input logic [1:0] r, input logic [1:0] c);
      return {1'b0, r, 1'b0} + {2'b00, r} + {2'b00, c};
   endfunction

   // Operand indices of the six triple products of the 3x3 determinant.
   function automatic logic [3:0] tri_idx(input logic [2:0] t, input logic [1:0] w);
      logic [11:0] e;
      case (t)
         3'd0:    e = {4'd0, 4'd4, 4'd8};
         3'd1:    e = {4'd1, 4'd5, 4'd6};
         3'd2:    e = {4'd2, 4'd3, 4'd7};
         3'd3:    e = {4'd2, 4'd4, 4'd6};
         3'd4:    e = {4'd1, 4'd3, 4'd8};
         3'd5:    e = {4'd0, 4'd5, 4'd7};
         default: e = '0;
      endcase
      case (w)
         2'd0:    return e[11:8];
         2'd1:    return e[7:4];
         default: return e[3:0];
      endcase
   endfunction

   // Cofactor operands: adj[e] = m[a]*m[b] - m[c]*m[d], e row-major.
   function automatic logic [3:0] cof_idx(input logic [3:0] e, input logic [1:0] w);
      logic [15:0] t;
      case (e)
         4'd0:    t = {4'd4, 4'd8, 4'd5, 4'd7};
         4'd1:    t = {4'd7, 4'd2, 4'd8, 4'd1};
         4'd2:    t = {4'd1, 4'd5, 4'd2, 4'd4};
         4'd3:    t = {4'd5, 4'd6, 4'd3, 4'd8};
         4'd4:    t = {4'd8, 4'd0, 4'd6, 4'd2};
         4'd5:    t = {4'd2, 4'd3, 4'd0, 4'd5};
         4'd6:    t = {4'd3, 4'd7, 4'd4, 4'd6};
         4'd7:    t = {4'd6, 4'd1, 4'd7, 4'd0};
         4'd8:    t = {4'd0, 4'd4, 4'd1, 4'd3};
         default: t = '0;
      endcase
      case (w)
         2'd0:    return t[15:12];
         2'd1:    return t[11:8];
         2'd2:    return t[7:4];
         default: return t[3:0];
      endcase
   endfunction

endpackage

// File: hw/rtl/jdi_queue.sv
// Short FIFO of finished points between the front and the back.
// Depends on jdi_pkg (point_type, QUEUE_DEPTH).
`timescale 1ns / 1ps
module jdi_queue (
   input  logic              clock,
   input  logic              reset,
   input  jdi_pkg::point_type push_data,
   input  logic              push_valid,
   output logic              push_ready,
   output jdi_pkg::point_type pop_data,
   output logic              pop_valid,
   input  logic              pop_ready
);
   import jdi_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam logic [PTR_W:0]   FULL_CNT = (PTR_W + 1)'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

   point_type          store_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ff, rd_ff;
   logic [PTR_W:0]     cnt_ff;
   logic               do_push, do_pop;

   assign push_ready = (cnt_ff != FULL_CNT);
   assign pop_valid  = (cnt_ff != '0);
   assign pop_data   = store_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= (wr_ff == LAST_PTR) ? '0 : wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == LAST_PTR) ? '0 : rd_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ff] <= push_data;
      end
   end

endmodule

// File: hw/rtl/jdi_mulq.sv
// Fixed-point multiply floor(a*b / 2^FRAC_BITS), 64x32 signed, saturated to 64 bits.
// Two 33x32 partial products on one multiplier; depends on jdi_pkg.
`timescale 1ns / 1ps
module jdi_mulq #(
   parameter int FRAC_BITS = jdi_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [63:0] a,
   input  logic signed [31:0] b,
   output logic               done,
   output logic signed [63:0] res
);
   import jdi_pkg::*;

   typedef enum logic [2:0] {M_IDLE, M_LO, M_HI, M_SUM, M_SAT} state_type;

   state_type          state_ff;
   logic signed [63:0] a_ff;
   logic signed [31:0] b_ff;
   logic signed [32:0] mul_x;
   logic signed [64:0] prod_in, plo_ff, phi_ff;
   logic signed [96:0] sum_in, sum_ff, shifted;
   logic signed [63:0] res_in, res_ff;
   logic               done_ff;

   assign mul_x   = (state_ff == M_LO) ? $signed({1'b0, a_ff[31:0]})
                                        : $signed({a_ff[63], a_ff[63:32]});
   assign prod_in = mul_x * b_ff;
   assign sum_in  = $signed({phi_ff, 32'd0}) + $signed({{32{plo_ff[64]}}, plo_ff});
   assign shifted = sum_ff >>> FRAC_BITS;

   always_comb begin
      if ((&shifted[96:63]) || !(|shifted[96:63])) begin
         res_in = shifted[63:0];
      end else begin
         res_in = shifted[96] ? S64_MIN : S64_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            M_IDLE: begin
               if (start) begin
                  a_ff     <= a;
                  b_ff     <= b;
                  state_ff <= M_LO;
               end
            end
            M_LO: begin
               plo_ff   <= prod_in;
               state_ff <= M_HI;
            end
            M_HI: begin
               phi_ff   <= prod_in;
               state_ff <= M_SUM;
            end
            M_SUM: begin
               sum_ff   <= sum_in;
               state_ff <= M_SAT;
            end
            M_SAT: begin
               res_ff   <= res_in;
               done_ff  <= 1'b1;
               state_ff <= M_IDLE;
            end
         endcase
      end
   end

   assign done = done_ff;
   assign res  = res_ff;

endmodule

// File: hw/rtl/jdi_divq.sv
// Radix-2 restoring divider: trunc(num * 2^FRAC_BITS / den), saturated to 32 bits.
// One quotient bit per cycle; depends on jdi_pkg.
`timescale 1ns / 1ps
module jdi_divq #(
   parameter int FRAC_BITS = jdi_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [63:0] num,
   input  logic signed [63:0] den,
   output logic               done,
   output logic [31:0]        quo
);
   import jdi_pkg::*;

   localparam int DVD_W = 64 + FRAC_BITS;
   localparam int CNT_W = $clog2(DVD_W);

   typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} state_type;

   state_type          state_ff;
   logic [DVD_W-1:0]   dvd_ff;
   logic [63:0]        ud_ff, rem_ff, num_mag, den_mag;
   logic [64:0]        rem_sh, rem_in;
   logic [33:0]        q_ff;
   logic [34:0]        q_in;
   logic               big_ff, neg_ff, ge, done_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [31:0]        quo_in, quo_ff;

   assign num_mag = num[63] ? 64'(-num) : 64'(num);
   assign den_mag = den[63] ? 64'(-den) : 64'(den);
   assign rem_sh  = {rem_ff, dvd_ff[DVD_W-1]};
   assign ge      = (rem_sh >= {1'b0, ud_ff});
   assign rem_in  = ge ? (rem_sh - {1'b0, ud_ff}) : rem_sh;
   assign q_in    = {q_ff, ge};

   always_comb begin
      if (neg_ff) begin
         quo_in = (big_ff || q_ff >= 34'h0_8000_0000) ? 32'h8000_0000 : 32'(-q_ff[31:0]);
      end else begin
         quo_in = (big_ff || q_ff > 34'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : q_ff[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            D_IDLE: begin
               if (start) begin
                  neg_ff   <= num[63] ^ den[63];
                  dvd_ff   <= {num_mag, {FRAC_BITS{1'b0}}};
                  ud_ff    <= den_mag;
                  rem_ff   <= '0;
                  q_ff     <= '0;
                  big_ff   <= 1'b0;
                  cnt_ff   <= CNT_W'(DVD_W - 1);
                  state_ff <= D_RUN;
               end
            end
            D_RUN: begin
               rem_ff <= rem_in[63:0];
               q_ff   <= q_in[33:0];
               big_ff <= big_ff || (q_in > 35'h1_0000_0000);
               dvd_ff <= {dvd_ff[DVD_W-2:0], 1'b0};
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  state_ff <= D_FIN;
               end
            end
            D_FIN: begin
               quo_ff   <= quo_in;
               done_ff  <= 1'b1;
               state_ff <= D_IDLE;
            end
            default: state_ff <= D_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// File: hw/rtl/jdi_front.sv
// Front end: accepts terms and accumulates the Jacobian sums, one product per cycle.
// Depends on jdi_pkg; pushes each finished point into jdi_queue.
`timescale 1ns / 1ps
module jdi_front #(
   parameter int FRAC_BITS = jdi_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [1:0]         dims,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_weight_x,
   input  logic signed [31:0] req_weight_y,
   input  logic signed [31:0] req_weight_z,
   input  logic signed [31:0] req_coord_x,
   input  logic signed [31:0] req_coord_y,
   input  logic signed [31:0] req_coord_z,
   input  logic               req_last_term,
   output jdi_pkg::point_type  push_data,
   output logic               push_valid,
   input  logic               push_ready
);
   import jdi_pkg::*;

   typedef enum logic [1:0] {F_IDLE, F_MUL, F_DRAIN, F_PUSH} state_type;

   state_type          state_ff;
   logic signed [31:0] w_ff [3];
   logic signed [31:0] x_ff [3];
   logic               last_ff, three_ff, pvld_ff;
   logic [1:0]         r_ff, c_ff, nmax;
   logic signed [63:0] prod_in, prod_ff, sum_in;
   logic [3:0]         pidx_ff;
   logic signed [63:0] sums_ff [9];

   assign nmax     = three_ff ? 2'd2 : 2'd1;
   assign prod_in  = w_ff[r_ff] * x_ff[c_ff];
   assign sum_in   = sat_add(sums_ff[pidx_ff], prod_ff >>> FRAC_BITS, 1'b0);
   assign req_ready  = (state_ff == F_IDLE);
   assign push_valid = (state_ff == F_PUSH);

   always_comb begin
      push_data.three = three_ff;
      for (int i = 0; i < 9; i++) begin
         push_data.m[i] = sat32(sums_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         pvld_ff  <= 1'b0;
         for (int i = 0; i < 9; i++) begin
            sums_ff[i] <= '0;
         end
      end else begin
         pvld_ff <= (state_ff == F_MUL);
         if (pvld_ff) begin
            sums_ff[pidx_ff] <= sum_in;
         end
         unique case (state_ff)
            F_IDLE: begin
               if (req_valid) begin
                  w_ff[0]  <= req_weight_x;
                  w_ff[1]  <= req_weight_y;
                  w_ff[2]  <= req_weight_z;
                  x_ff[0]  <= req_coord_x;
                  x_ff[1]  <= req_coord_y;
                  x_ff[2]  <= req_coord_z;
                  last_ff  <= req_last_term;
                  three_ff <= (dims == DIMS_3D);
                  r_ff     <= '0;
                  c_ff     <= '0;
                  state_ff <= F_MUL;
               end
            end
            F_MUL: begin
               prod_ff <= prod_in;
               pidx_ff <= idx9(r_ff, c_ff);
               if (c_ff == nmax) begin
                  c_ff <= '0;
                  r_ff <= r_ff + 1'b1;
                  if (r_ff == nmax) begin
                     state_ff <= F_DRAIN;
                  end
               end else begin
                  c_ff <= c_ff + 1'b1;
               end
            end
            F_DRAIN: begin
               state_ff <= last_ff ? F_PUSH : F_IDLE;
            end
            F_PUSH: begin
               if (push_ready) begin
                  for (int i = 0; i < 9; i++) begin
                     sums_ff[i] <= '0;
                  end
                  state_ff <= F_IDLE;
               end
            end
         endcase
      end
   end

endmodule

// File: hw/rtl/jdi_back.sv
// Back end: determinant and 3D adjugate on a shared multiply unit, division, result emission.
// Depends on jdi_pkg, jdi_mulq and jdi_divq; pops points from jdi_queue.
`timescale 1ns / 1ps
module jdi_back #(
   parameter int FRAC_BITS = jdi_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  jdi_pkg::point_type  pop_data,
   input  logic               pop_valid,
   output logic               pop_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_kind,
   output logic [1:0]         rsp_row,
   output logic [1:0]         rsp_col,
   output logic signed [31:0] rsp_value,
   output logic               rsp_singular,
   output logic               rsp_end_of_point
);
   import jdi_pkg::*;

   typedef enum logic [3:0] {
      B_IDLE, B_OPA, B_OPB, B_MWAIT, B_JAC, B_INV_GO, B_INV_WAIT, B_INV_OUT, B_DET
   } state_type;
   typedef enum logic [1:0] {OP_TMP, OP_ADD, OP_SUB} mode_type;

   localparam logic [3:0] TRI_LAST = 4'd5;
   localparam logic [3:0] COF_LAST = 4'd8;
   localparam logic [3:0] TRI_SUB0 = 4'd3;

   state_type          state_ff;
   logic [8:0][31:0]   m_ff;
   logic               three_ff, det_phase_ff, half_ff, sing_ff;
   logic [3:0]         grp_ff, ia, ib, rd_idx, emit_idx;
   logic               a_tmp, can_load, emit_last;
   mode_type           mode;
   logic signed [63:0] tmp_ff, acc_ff, det_ff, opa_ff, acc_in, div_num_ff, mul_res;
   logic signed [31:0] opb_ff, inv_q_ff;
   logic signed [63:0] adj_ff [9];
   logic [1:0]         er_ff, ec_ff, nmax;
   logic [31:0]        m_rd, div_quo;
   logic               mul_start_ff, mul_done, div_start_ff, div_done;
   logic               rsp_valid_ff, rsp_sing_ff, rsp_eop_ff;
   kind_type           rsp_kind_ff;
   logic [1:0]         rsp_row_ff, rsp_col_ff;
   logic [31:0]        rsp_value_ff;

   jdi_mulq #(.FRAC_BITS(FRAC_BITS)) u_mulq (
      .clock (clock),
      .reset (reset),
      .start (mul_start_ff),
      .a     (opa_ff),
      .b     (opb_ff),
      .done  (mul_done),
      .res   (mul_res)
   );

   jdi_divq #(.FRAC_BITS(FRAC_BITS)) u_divq (
      .clock (clock),
      .reset (reset),
      .start (div_start_ff),
      .num   (div_num_ff),
      .den   (det_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   // operand decode for the current multiply step
   always_comb begin
      a_tmp = 1'b0;
      ia    = '0;
      ib    = '0;
      mode  = OP_ADD;
      if (three_ff && det_phase_ff) begin
         if (!half_ff) begin
            ia   = tri_idx(grp_ff[2:0], 2'd0);
            ib   = tri_idx(grp_ff[2:0], 2'd1);
            mode = OP_TMP;
         end else begin
            a_tmp = 1'b1;
            ib    = tri_idx(grp_ff[2:0], 2'd2);
            mode  = (grp_ff < TRI_SUB0) ? OP_ADD : OP_SUB;
         end
      end else if (three_ff) begin
         ia   = half_ff ? cof_idx(grp_ff, 2'd2) : cof_idx(grp_ff, 2'd0);
         ib   = half_ff ? cof_idx(grp_ff, 2'd3) : cof_idx(grp_ff, 2'd1);
         mode = half_ff ? OP_SUB : OP_ADD;
      end else begin
         ia   = half_ff ? idx9(2'd0, 2'd1) : idx9(2'd0, 2'd0);
         ib   = half_ff ? idx9(2'd1, 2'd0) : idx9(2'd1, 2'd1);
         mode = half_ff ? OP_SUB : OP_ADD;
      end
   end

   assign emit_idx  = idx9(er_ff, ec_ff);
   assign rd_idx    = (state_ff == B_OPA) ? ia : ((state_ff == B_OPB) ? ib : emit_idx);
   assign m_rd      = m_ff[rd_idx];
   assign acc_in    = sat_add(acc_ff, mul_res, mode == OP_SUB);
   assign nmax      = three_ff ? 2'd2 : 2'd1;
   assign emit_last = (er_ff == nmax) && (ec_ff == nmax);
   assign can_load  = !rsp_valid_ff || rsp_ready;
   assign pop_ready = (state_ff == B_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         mul_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mul_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
         if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            B_IDLE: begin
               if (pop_valid) begin
                  m_ff         <= pop_data.m;
                  three_ff     <= pop_data.three;
                  acc_ff       <= '0;
                  grp_ff       <= '0;
                  half_ff      <= 1'b0;
                  det_phase_ff <= 1'b1;
                  er_ff        <= '0;
                  ec_ff        <= '0;
                  state_ff     <= B_OPA;
               end
            end
            B_OPA: begin
               opa_ff   <= a_tmp ? tmp_ff : sext32(m_rd);
               state_ff <= B_OPB;
            end
            B_OPB: begin
               opb_ff       <= m_rd;
               mul_start_ff <= 1'b1;
               state_ff     <= B_MWAIT;
            end
            B_MWAIT: begin
               if (mul_done) begin
                  state_ff <= B_OPA;
                  if (mode == OP_TMP) begin
                     tmp_ff  <= mul_res;
                     half_ff <= 1'b1;
                  end else begin
                     acc_ff  <= acc_in;
                     half_ff <= ~half_ff;
                     if (half_ff) begin
                        if (three_ff && det_phase_ff) begin
                           if (grp_ff == TRI_LAST) begin
                              det_ff       <= acc_in;
                              sing_ff      <= (acc_in == '0);
                              acc_ff       <= '0;
                              det_phase_ff <= 1'b0;
                              grp_ff       <= '0;
                           end else begin
                              grp_ff <= grp_ff + 1'b1;
                           end
                        end else if (three_ff) begin
                           adj_ff[grp_ff] <= acc_in;
                           acc_ff         <= '0;
                           if (grp_ff == COF_LAST) begin
                              state_ff <= B_JAC;
                           end else begin
                              grp_ff <= grp_ff + 1'b1;
                           end
                        end else begin
                           det_ff    <= acc_in;
                           sing_ff   <= (acc_in == '0);
                           acc_ff    <= '0;
                           adj_ff[0] <= sext32(m_ff[4]);
                           adj_ff[1] <= -sext32(m_ff[1]);
                           adj_ff[3] <= -sext32(m_ff[3]);
                           adj_ff[4] <= sext32(m_ff[0]);
                           state_ff  <= B_JAC;
                        end
                     end
                  end
               end
            end
            B_JAC: begin
               if (can_load) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_kind_ff  <= KIND_JAC;
                  rsp_row_ff   <= er_ff;
                  rsp_col_ff   <= ec_ff;
                  rsp_value_ff <= m_rd;
                  rsp_sing_ff  <= sing_ff;
                  rsp_eop_ff   <= 1'b0;
                  if (ec_ff == nmax) begin
                     ec_ff <= '0;
                     er_ff <= er_ff + 1'b1;
                  end else begin
                     ec_ff <= ec_ff + 1'b1;
                  end
                  if (emit_last) begin
                     er_ff    <= '0;
                     state_ff <= B_INV_GO;
                  end
               end
            end
            B_INV_GO: begin
               if (sing_ff) begin
                  inv_q_ff <= '0;
                  state_ff <= B_INV_OUT;
               end else begin
                  div_num_ff   <= adj_ff[emit_idx];
                  div_start_ff <= 1'b1;
                  state_ff     <= B_INV_WAIT;
               end
            end
            B_INV_WAIT: begin
               if (div_done) begin
                  inv_q_ff <= div_quo;
                  state_ff <= B_INV_OUT;
               end
            end
            B_INV_OUT: begin
               if (can_load) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_kind_ff  <= KIND_INV;
                  rsp_row_ff   <= er_ff;
                  rsp_col_ff   <= ec_ff;
                  rsp_value_ff <= inv_q_ff;
                  rsp_sing_ff  <= sing_ff;
                  rsp_eop_ff   <= 1'b0;
                  state_ff     <= B_INV_GO;
                  if (ec_ff == nmax) begin
                     ec_ff <= '0;
                     er_ff <= er_ff + 1'b1;
                  end else begin
                     ec_ff <= ec_ff + 1'b1;
                  end
                  if (emit_last) begin
                     state_ff <= B_DET;
                  end
               end
            end
            B_DET: begin
               if (can_load) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_kind_ff  <= KIND_DET;
                  rsp_row_ff   <= '0;
                  rsp_col_ff   <= '0;
                  rsp_value_ff <= sat32(det_ff);
                  rsp_sing_ff  <= sing_ff;
                  rsp_eop_ff   <= 1'b1;
                  state_ff     <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_row          = rsp_row_ff;
   assign rsp_col          = rsp_col_ff;
   assign rsp_value        = rsp_value_ff;
   assign rsp_singular     = rsp_sing_ff;
   assign rsp_end_of_point = rsp_eop_ff;

   a_sing_inv_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_sing_ff && (rsp_kind_ff == KIND_INV) |-> rsp_value_ff == '0)
      else $error("singular point emitted a nonzero inverse entry");

   a_mul_done_waited: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> state_ff == B_MWAIT)
      else $error("multiply result arrived outside the wait state");

   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == B_INV_WAIT)
      else $error("quotient arrived outside the wait state");

endmodule

// File: hw/rtl/jacobian_det_inverse_top.sv
// The front forms the n*n products of each term, one product per cycle (n = 2 or 3),
// and adds them to the sums. After the last term the back runs its multiply steps
// (2 steps in 2D, 30 in 3D), then the bit-serial divider once per inverse entry of a nonsingular point.
// The front takes a new term only when done with the last, and the back a new point only
// when done with the last; short runs are paced by the back; a two-entry queue decouples.
// Reset: synchronous, active high; clears sums, queue, handshakes and sets dims to 2.
`timescale 1ns / 1ps
module jacobian_det_inverse_top #(
   parameter int FRAC_BITS = jdi_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   // configuration write channel
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_dims,
   // term input channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_weight_x,
   input  logic signed [31:0] req_weight_y,
   input  logic signed [31:0] req_weight_z,
   input  logic signed [31:0] req_coord_x,
   input  logic signed [31:0] req_coord_y,
   input  logic signed [31:0] req_coord_z,
   input  logic               req_last_term,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_kind,
   output logic [1:0]         rsp_row,
   output logic [1:0]         rsp_col,
   output logic signed [31:0] rsp_value,
   output logic               rsp_singular,
   output logic               rsp_end_of_point
);
   import jdi_pkg::*;

   logic [1:0] dims_ff;
   point_type  push_data, pop_data;
   logic       push_valid, push_ready, pop_valid, pop_ready;

   // the register takes a transfer on every cycle; the user must write only while idle, the block does not enforce it
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff <= DIMS_RESET;
      end else if (csr_valid) begin
         dims_ff <= csr_dims;
      end
   end

   // front: accept terms, accumulate sums, hand finished points to the queue
   jdi_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock         (clock),
      .reset         (reset),
      .dims          (dims_ff),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_weight_x  (req_weight_x),
      .req_weight_y  (req_weight_y),
      .req_weight_z  (req_weight_z),
      .req_coord_x   (req_coord_x),
      .req_coord_y   (req_coord_y),
      .req_coord_z   (req_coord_z),
      .req_last_term (req_last_term),
      .push_data     (push_data),
      .push_valid    (push_valid),
      .push_ready    (push_ready)
   );

   // hold finished points so either side can stall on its own
   jdi_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_data  (push_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .pop_data   (pop_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready)
   );

   // back: determinant, adjugate, division and the ordered result stream
   jdi_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_data         (pop_data),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_row          (rsp_row),
      .rsp_col          (rsp_col),
      .rsp_value        (rsp_value),
      .rsp_singular     (rsp_singular),
      .rsp_end_of_point (rsp_end_of_point)
   );

endmodule
